@@ design/qrvs_pkg.sv @@
package qrvs_pkg;

   localparam int QUAT_WIDTH = 18;
   localparam int QUAT_FRAC  = 16;
   localparam int FUNC_WIDTH = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int STEP_W     = 6;
   localparam int OPND_IDX_W = 4;
   localparam int NUM_OPND   = 13;
   localparam int NUM_SLOT   = 7;

   // item kinds
   localparam logic [FUNC_WIDTH-1:0] FN_VERTEX = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FN_POINT  = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FN_KEY    = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FN_REPORT = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FN_CLEAR  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_W = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_X = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_Y = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_Z = 2'd3;

   // operand file layout
   localparam logic [OPND_IDX_W-1:0] OP_POS = 4'd0;
   localparam logic [OPND_IDX_W-1:0] OP_NRM = 4'd3;
   localparam logic [OPND_IDX_W-1:0] OP_KW  = 4'd6;
   localparam logic [OPND_IDX_W-1:0] OP_T1P = 4'd7;
   localparam logic [OPND_IDX_W-1:0] OP_T1N = 4'd10;

   // result slots: out x y z w, aux x y z
   localparam logic [OPND_IDX_W-1:0] SLOT_POS = 4'd0;
   localparam logic [OPND_IDX_W-1:0] SLOT_W   = 4'd3;
   localparam logic [OPND_IDX_W-1:0] SLOT_NRM = 4'd4;

   typedef enum logic [2:0] {QS_W, QS_X, QS_Y, QS_Z, QS_ONE} qsel_type;

   typedef struct packed {
      logic                  valid;
      qsel_type              qsel;
      logic [OPND_IDX_W-1:0] osel;
      logic                  sub;
      logic                  dbl;
      logic                  first;
      logic                  last;
      logic                  to_out;
      logic [OPND_IDX_W-1:0] dst;
   } uop_type;

   typedef struct packed {
      logic                  valid;
      logic                  sub;
      logic                  dbl;
      logic                  first;
      logic                  last;
      logic                  to_out;
      logic [OPND_IDX_W-1:0] dst;
   } ctl_type;

   function automatic logic [1:0] nxt1(logic [1:0] i);
      case (i)
         2'd0:    return 2'd1;
         2'd1:    return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] nxt2(logic [1:0] i);
      case (i)
         2'd0:    return 2'd2;
         2'd1:    return 2'd0;
         default: return 2'd1;
      endcase
   endfunction

   function automatic qsel_type qvec(logic [1:0] i);
      case (i)
         2'd0:    return QS_X;
         2'd1:    return QS_Y;
         default: return QS_Z;
      endcase
   endfunction

   // t1 = q x v, two terms per component
   function automatic uop_type t1_uop(logic [OPND_IDX_W-1:0] vbase,
                                      logic [OPND_IDX_W-1:0] tbase, logic [2:0] j);
      uop_type    u;
      logic [1:0] i;
      u = '0;
      i = j[2:1];
      u.valid = 1'b1;
      if (!j[0]) begin
         u.qsel  = qvec(nxt1(i));
         u.osel  = vbase + {2'b00, nxt2(i)};
         u.first = 1'b1;
      end else begin
         u.qsel = qvec(nxt2(i));
         u.osel = vbase + {2'b00, nxt1(i)};
         u.sub  = 1'b1;
         u.last = 1'b1;
         u.dst  = tbase + {2'b00, i};
      end
      return u;
   endfunction

   // r = v + 2*(w*t1 + q x t1), four terms per component
   function automatic uop_type rot_uop(logic [OPND_IDX_W-1:0] vbase,
                                       logic [OPND_IDX_W-1:0] tbase,
                                       logic [OPND_IDX_W-1:0] slot, logic [3:0] j);
      uop_type    u;
      logic [1:0] i;
      u = '0;
      i = j[3:2];
      u.valid = 1'b1;
      case (j[1:0])
         2'd0: begin
            u.qsel  = QS_ONE;
            u.osel  = vbase + {2'b00, i};
            u.first = 1'b1;
         end
         2'd1: begin
            u.qsel = QS_W;
            u.osel = tbase + {2'b00, i};
            u.dbl  = 1'b1;
         end
         2'd2: begin
            u.qsel = qvec(nxt1(i));
            u.osel = tbase + {2'b00, nxt2(i)};
            u.dbl  = 1'b1;
         end
         default: begin
            u.qsel   = qvec(nxt2(i));
            u.osel   = tbase + {2'b00, nxt1(i)};
            u.dbl    = 1'b1;
            u.sub    = 1'b1;
            u.last   = 1'b1;
            u.to_out = 1'b1;
            u.dst    = slot + {2'b00, i};
         end
      endcase
      return u;
   endfunction

   // hamilton product key * rot
   function automatic uop_type key_uop(logic [3:0] j);
      uop_type    u;
      logic [1:0] i;
      logic [1:0] k;
      u = '0;
      i = j[3:2];
      k = j[1:0] - 2'd1;
      u.valid = 1'b1;
      if (i != 2'd3) begin
         case (j[1:0])
            2'd0: begin
               u.qsel  = qvec(i);
               u.osel  = OP_KW;
               u.first = 1'b1;
            end
            2'd1: begin
               u.qsel = QS_W;
               u.osel = OP_POS + {2'b00, i};
            end
            2'd2: begin
               u.qsel = qvec(nxt2(i));
               u.osel = OP_POS + {2'b00, nxt1(i)};
            end
            default: begin
               u.qsel   = qvec(nxt1(i));
               u.osel   = OP_POS + {2'b00, nxt2(i)};
               u.sub    = 1'b1;
               u.last   = 1'b1;
               u.to_out = 1'b1;
               u.dst    = SLOT_POS + {2'b00, i};
            end
         endcase
      end else if (j[1:0] == 2'd0) begin
         u.qsel  = QS_W;
         u.osel  = OP_KW;
         u.first = 1'b1;
      end else begin
         u.qsel = qvec(k);
         u.osel = OP_POS + {2'b00, k};
         u.sub  = 1'b1;
         if (j[1:0] == 2'd3) begin
            u.last   = 1'b1;
            u.to_out = 1'b1;
            u.dst    = SLOT_W;
         end
      end
      return u;
   endfunction

   function automatic uop_type uop_at(logic [FUNC_WIDTH-1:0] fn, logic [STEP_W-1:0] step);
      uop_type u;
      u = '0;
      case (fn)
         FN_VERTEX: begin
            if (step < 6'd6)
               u = t1_uop(OP_POS, OP_T1P, step[2:0]);
            else if (step < 6'd12)
               u = t1_uop(OP_NRM, OP_T1N, 3'(step - 6'd6));
            else if (step < 6'd24)
               u = rot_uop(OP_POS, OP_T1P, SLOT_POS, 4'(step - 6'd12));
            else if (step < 6'd36)
               u = rot_uop(OP_NRM, OP_T1N, SLOT_NRM, 4'(step - 6'd24));
         end
         FN_POINT: begin
            if (step < 6'd6)
               u = t1_uop(OP_POS, OP_T1P, step[2:0]);
            else if (step >= 6'd8 && step < 6'd20)
               u = rot_uop(OP_POS, OP_T1P, SLOT_POS, 4'(step - 6'd8));
         end
         FN_KEY: begin
            if (step < 6'd16)
               u = key_uop(step[3:0]);
         end
         default: u = '0;
      endcase
      return u;
   endfunction

   function automatic logic [STEP_W-1:0] prog_len(logic [FUNC_WIDTH-1:0] fn);
      case (fn)
         FN_VERTEX: return 6'd36;
         FN_POINT:  return 6'd20;
         FN_KEY:    return 6'd16;
         default:   return 6'd0;
      endcase
   endfunction

endpackage

@@ design/qrvs_if.sv @@
interface qrvs_req_if import qrvs_pkg::*; #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic [FUNC_WIDTH-1:0]         func;
   logic signed [COORD_WIDTH-1:0] in_x;
   logic signed [COORD_WIDTH-1:0] in_y;
   logic signed [COORD_WIDTH-1:0] in_z;
   logic signed [COORD_WIDTH-1:0] in_w;
   logic signed [COORD_WIDTH-1:0] normal_x;
   logic signed [COORD_WIDTH-1:0] normal_y;
   logic signed [COORD_WIDTH-1:0] normal_z;

   modport source (output valid, func, in_x, in_y, in_z, in_w, normal_x, normal_y, normal_z,
                   input ready);
   modport sink (input valid, func, in_x, in_y, in_z, in_w, normal_x, normal_y, normal_z,
                 output ready);
endinterface

interface qrvs_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic signed [COORD_WIDTH-1:0] out_z;
   logic signed [COORD_WIDTH-1:0] out_w;
   logic signed [COORD_WIDTH-1:0] aux_x;
   logic signed [COORD_WIDTH-1:0] aux_y;
   logic signed [COORD_WIDTH-1:0] aux_z;
   logic                          box_valid;

   modport source (output valid, out_x, out_y, out_z, out_w, aux_x, aux_y, aux_z, box_valid,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, out_w, aux_x, aux_y, aux_z, box_valid,
                 output ready);
endinterface

@@ design/quaternion_rotate_vertex_stream.sv @@
// channel   dir  handshake          payload
// req_if    in   valid / ready      func, in_x..in_w, normal_x..normal_z
// rsp_if    out  valid / ready      out_x..out_w, aux_x..aux_z, box_valid
// csr       in   csr_we             csr_index, csr_wdata (rot_w, rot_x, rot_y, rot_z)
//
// items are taken one at a time, the next only once the last has left the done state.
// an item's program runs 36 products for a vertex, 18 products and two wait steps for t1
// for a point, 16 products for a rotation key, and none for report or clear.
// it runs on the single 18 x (COORD_WIDTH+3) multiplier, one product per cycle,
// and its three-stage multiply / round / accumulate path that is drained at the end.
// reset (synchronous) gives the identity rotation and an empty, zeroed box.
// a finished result waits in the output register; the next item is taken meanwhile,
// and its own result holds in the done state until the one before it is taken.
module quaternion_rotate_vertex_stream import qrvs_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   qrvs_req_if.sink              req_if,
   qrvs_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [QUAT_WIDTH-1:0] csr_wdata
);

   // operand width holds q x v, accumulator width holds v + 2*(w*t1 + q x t1)
   localparam int OPW  = COORD_WIDTH + 3;
   localparam int ACCW = COORD_WIDTH + 6;
   localparam int PW   = QUAT_WIDTH + OPW;

   localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1 << QUAT_FRAC);
   localparam logic signed [PW-1:0] RND_HALF = PW'(1 << (QUAT_FRAC - 1));
   localparam logic signed [ACCW-1:0] SAT_HI =
      {{(ACCW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic signed [ACCW-1:0] SAT_LO =
      {{(ACCW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   function automatic logic signed [OPW-1:0] sext_op(logic [COORD_WIDTH-1:0] v);
      return {{(OPW - COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
   endfunction

   // sequencer
   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [FUNC_WIDTH-1:0] func_ff;
   uop_type               uop;
   logic                  req_fire, rsp_fire, finish;

   // rotation registers
   logic signed [QUAT_WIDTH-1:0] rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;

   // operand file: position, normal, key w, t1 of position, t1 of normal
   logic signed [OPW-1:0]         opnd_ff [NUM_OPND];
   logic signed [COORD_WIDTH-1:0] res_ff  [NUM_SLOT];

   // multiply / round / accumulate path
   logic signed [QUAT_WIDTH-1:0] q_op;
   logic signed [OPW-1:0]        v_op;
   logic signed [PW-1:0]         p_ff, p_in, p_adj;
   logic signed [ACCW-1:0]       rnd_ff, rnd_in;
   logic signed [ACCW-1:0]       acc_ff, term, base, acc_sum;
   logic signed [COORD_WIDTH-1:0] acc_sat;
   ctl_type                      ctl1_ff, ctl1_in, ctl2_ff;

   // box and output register
   logic signed [COORD_WIDTH-1:0] box_low_ff [3], box_low_in [3];
   logic signed [COORD_WIDTH-1:0] box_high_ff [3], box_high_in [3];
   logic                          box_nonempty_ff, box_nonempty_in;
   logic signed [COORD_WIDTH-1:0] out_ff [NUM_SLOT], out_in [NUM_SLOT];
   logic                          box_valid_ff;
   logic                          rsp_valid_ff;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_fire     = rsp_if.valid && rsp_if.ready;
   assign finish       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign uop          = uop_at(func_ff, step_ff);

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               step_in  = '0;
               state_in = (prog_len(req_if.func) != '0) ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == prog_len(func_ff) - 1'b1)
               state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!ctl1_ff.valid && !ctl2_ff.valid)
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (finish)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire)
         func_ff <= req_if.func;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff <= QUAT_ONE;
         rot_x_ff <= '0;
         rot_y_ff <= '0;
         rot_z_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_W: rot_w_ff <= csr_wdata;
            CSR_ROT_X: rot_x_ff <= csr_wdata;
            CSR_ROT_Y: rot_y_ff <= csr_wdata;
            CSR_ROT_Z: rot_z_ff <= csr_wdata;
            default:   rot_w_ff <= rot_w_ff;
         endcase
      end
   end

   // issue: operand select and the shared multiplier
   always_comb begin
      case (uop.qsel)
         QS_W:    q_op = rot_w_ff;
         QS_X:    q_op = rot_x_ff;
         QS_Y:    q_op = rot_y_ff;
         QS_Z:    q_op = rot_z_ff;
         QS_ONE:  q_op = QUAT_ONE;
         default: q_op = '0;
      endcase
      v_op = opnd_ff[uop.osel];
      p_in = q_op * v_op;

      ctl1_in.valid  = (state_ff == ST_RUN) && uop.valid;
      ctl1_in.sub    = uop.sub;
      ctl1_in.dbl    = uop.dbl;
      ctl1_in.first  = uop.first;
      ctl1_in.last   = uop.last;
      ctl1_in.to_out = uop.to_out;
      ctl1_in.dst    = uop.dst;
   end

   // round half away from zero: floor((p + half - [p < 0]) / 2^frac)
   always_comb begin
      p_adj  = p_ff + RND_HALF - $signed({{(PW - 1){1'b0}}, p_ff[PW-1]});
      rnd_in = ACCW'(p_adj >>> QUAT_FRAC);
   end

   // accumulate, with saturation on the way out
   always_comb begin
      term    = ctl2_ff.dbl ? (rnd_ff <<< 1) : rnd_ff;
      base    = ctl2_ff.first ? '0 : acc_ff;
      acc_sum = ctl2_ff.sub ? (base - term) : (base + term);
      if (acc_sum > SAT_HI)
         acc_sat = SAT_HI[COORD_WIDTH-1:0];
      else if (acc_sum < SAT_LO)
         acc_sat = SAT_LO[COORD_WIDTH-1:0];
      else
         acc_sat = acc_sum[COORD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      rnd_ff <= rnd_in;
      if (ctl2_ff.valid)
         acc_ff <= acc_sum;
   end

   // operand file and result slots
   always_ff @(posedge clock) begin
      if (req_fire) begin
         opnd_ff[OP_POS]        <= sext_op(req_if.in_x);
         opnd_ff[OP_POS + 4'd1] <= sext_op(req_if.in_y);
         opnd_ff[OP_POS + 4'd2] <= sext_op(req_if.in_z);
         opnd_ff[OP_NRM]        <= sext_op(req_if.normal_x);
         opnd_ff[OP_NRM + 4'd1] <= sext_op(req_if.normal_y);
         opnd_ff[OP_NRM + 4'd2] <= sext_op(req_if.normal_z);
         opnd_ff[OP_KW]         <= sext_op(req_if.in_w);
         for (int k = 0; k < NUM_SLOT; k++)
            res_ff[k] <= '0;
      end else if (ctl2_ff.valid && ctl2_ff.last) begin
         if (ctl2_ff.to_out)
            res_ff[ctl2_ff.dst[2:0]] <= acc_sat;
         else
            opnd_ff[ctl2_ff.dst] <= OPW'(acc_sum);
      end
   end

   // bounding box and result select at the end of the item
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         box_low_in[i]  = box_low_ff[i];
         box_high_in[i] = box_high_ff[i];
      end
      box_nonempty_in = box_nonempty_ff;
      if (finish) begin
         case (func_ff)
            FN_VERTEX: begin
               for (int i = 0; i < 3; i++) begin
                  if (!box_nonempty_ff || res_ff[i] < box_low_ff[i])
                     box_low_in[i] = res_ff[i];
                  if (!box_nonempty_ff || res_ff[i] > box_high_ff[i])
                     box_high_in[i] = res_ff[i];
               end
               box_nonempty_in = 1'b1;
            end
            FN_CLEAR: begin
               for (int i = 0; i < 3; i++) begin
                  box_low_in[i]  = '0;
                  box_high_in[i] = '0;
               end
               box_nonempty_in = 1'b0;
            end
            default: box_nonempty_in = box_nonempty_ff;
         endcase
      end

      for (int k = 0; k < NUM_SLOT; k++)
         out_in[k] = '0;
      case (func_ff) inside
         FN_VERTEX, FN_POINT, FN_KEY: begin
            for (int k = 0; k < NUM_SLOT; k++)
               out_in[k] = res_ff[k];
         end
         FN_REPORT: begin
            for (int i = 0; i < 3; i++) begin
               out_in[i]     = box_low_ff[i];
               out_in[4 + i] = box_high_ff[i];
            end
         end
         default: out_in[0] = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_low_ff[i]  <= '0;
            box_high_ff[i] <= '0;
         end
         box_nonempty_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         for (int i = 0; i < 3; i++) begin
            box_low_ff[i]  <= box_low_in[i];
            box_high_ff[i] <= box_high_in[i];
         end
         box_nonempty_ff <= box_nonempty_in;
         if (finish)
            rsp_valid_ff <= 1'b1;
         else if (rsp_fire)
            rsp_valid_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (finish) begin
         for (int k = 0; k < NUM_SLOT; k++)
            out_ff[k] <= out_in[k];
         box_valid_ff <= box_nonempty_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_x     = out_ff[0];
   assign rsp_if.out_y     = out_ff[1];
   assign rsp_if.out_z     = out_ff[2];
   assign rsp_if.out_w     = out_ff[3];
   assign rsp_if.aux_x     = out_ff[4];
   assign rsp_if.aux_y     = out_ff[5];
   assign rsp_if.aux_z     = out_ff[6];
   assign rsp_if.box_valid = box_valid_ff;

   // results are only taken once the multiply path has drained
   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!ctl1_ff.valid && !ctl2_ff.valid))
      else $error("result taken with products still in flight");

   // the step counter stays inside the running program
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff < prog_len(func_ff)))
      else $error("step counter past end of program");

   // a filled box is always ordered
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      box_nonempty_ff |-> (box_low_ff[0] <= box_high_ff[0] &&
                           box_low_ff[1] <= box_high_ff[1] &&
                           box_low_ff[2] <= box_high_ff[2]))
      else $error("bounding box minimum above maximum");

   // a clear item empties the box
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (finish && func_ff == FN_CLEAR) |=> (!box_nonempty_ff && !rsp_if.box_valid))
      else $error("box not empty after clear");

endmodule

@@ test/quaternion_rotate_vertex_stream_test.sv @@
`timescale 1ns / 1ps

module quaternion_rotate_vertex_stream_test import qrvs_pkg::*; ();

   localparam int COORD_WIDTH     = 32;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int NUM_PHASES      = 10;
   localparam int CALM_ITEMS      = 150;
   localparam int TAIL_CYCLES     = 60;
   localparam int TIMEOUT_NS      = 8_000_000;

   // func codes the block leaves unused
   localparam logic [FUNC_WIDTH-1:0] FN_UNUSED_5 = 3'd5;
   localparam logic [FUNC_WIDTH-1:0] FN_UNUSED_6 = 3'd6;
   localparam logic [FUNC_WIDTH-1:0] FN_UNUSED_7 = 3'd7;

   localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

   localparam logic signed [QUAT_WIDTH-1:0] Q_ZERO = 18'sd0;
   localparam logic signed [QUAT_WIDTH-1:0] Q_ONE  = 18'sd65536;
   localparam logic signed [QUAT_WIDTH-1:0] Q_HALF = 18'sd32768;
   localparam logic signed [QUAT_WIDTH-1:0] Q_R2   = 18'sd46341;
   localparam logic signed [QUAT_WIDTH-1:0] Q_MAX  = 18'sh1FFFF;
   localparam logic signed [QUAT_WIDTH-1:0] Q_MIN  = 18'sh20000;

   // inner sums saturate at +-(2^62-1), results at the coordinate range
   localparam longint SUM_LIM  = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam longint COORD_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam longint COORD_LO = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic signed [31:0]    in_x, in_y, in_z, in_w;
      logic signed [31:0]    normal_x, normal_y, normal_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x, out_y, out_z, out_w;
      logic signed [31:0] aux_x, aux_y, aux_z;
      logic               box_valid;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type want;
   } row_type;

   typedef struct packed {
      logic signed [QUAT_WIDTH-1:0] w, x, y, z;
   } quat_type;

   typedef longint vec3_type [3];

   localparam string FIELD_NAMES [8] = '{"out_x", "out_y", "out_z", "out_w",
                                         "aux_x", "aux_y", "aux_z", "box_valid"};

   // directed items, all under the identity rotation left by reset;
   // rows with typed = 0 take their expectation from the predictor
   localparam row_type DIRECTED [20] = '{
      // report and clear of the empty box after reset
      '{'{FN_REPORT, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1'b0}},
      '{'{FN_CLEAR, -1, -1, -1, -1, -1, -1, -1}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1'b0}},
      // first vertex seeds the box, extremes pass unchanged
      '{'{FN_VERTEX, C_MAX, C_MIN, 0, 5, C_MIN, C_MAX, -1}, 1'b1,
        '{C_MAX, C_MIN, 0, 0, C_MIN, C_MAX, -1, 1'b1}},
      '{'{FN_REPORT, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
        '{C_MAX, C_MIN, 0, 0, C_MAX, C_MIN, 0, 1'b1}},
      // second vertex widens the box on every axis
      '{'{FN_VERTEX, C_MIN, C_MAX, 5, 0, 0, 0, 0}, 1'b1,
        '{C_MIN, C_MAX, 5, 0, 0, 0, 0, 1'b1}},
      '{'{FN_REPORT, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
        '{C_MIN, C_MIN, 0, 0, C_MAX, C_MAX, 5, 1'b1}},
      // point and key ignore the fields they do not use
      '{'{FN_POINT, 1, -2, 3, 9, 7, 7, 7}, 1'b1, '{1, -2, 3, 0, 0, 0, 0, 1'b1}},
      '{'{FN_KEY, C_MIN, C_MAX, 7, -9, 3, 3, 3}, 1'b1,
        '{C_MIN, C_MAX, 7, -9, 0, 0, 0, 1'b1}},
      // unused codes touch nothing
      '{'{FN_UNUSED_5, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1'b1,
        '{0, 0, 0, 0, 0, 0, 0, 1'b1}},
      '{'{FN_UNUSED_6, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, 1'b1,
        '{0, 0, 0, 0, 0, 0, 0, 1'b1}},
      '{'{FN_UNUSED_7, -1, -1, -1, -1, -1, -1, -1}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1'b1}},
      '{'{FN_REPORT, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
        '{C_MIN, C_MIN, 0, 0, C_MAX, C_MAX, 5, 1'b1}},
      // clear, then report of the cleared box
      '{'{FN_CLEAR, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1'b0}},
      '{'{FN_REPORT, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1'b0}},
      // first vertex after clear, then a few left to the predictor
      '{'{FN_VERTEX, -100, 200, -300, 0, 65536, 0, -65536}, 1'b0, '0},
      '{'{FN_VERTEX, 50, -400, -10, 0, 0, 0, 0}, 1'b0, '0},
      '{'{FN_REPORT, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
      '{'{FN_POINT, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN}, 1'b0, '0},
      '{'{FN_KEY, 0, 0, 0, 65536, 0, 0, 0}, 1'b0, '0},
      '{'{FN_KEY, C_MAX, C_MAX, C_MAX, C_MAX, 0, 0, 0}, 1'b0, '0}
   };

   // rotations for the random phases; the rest are drawn at random
   localparam quat_type ROT_PLAN [8] = '{
      '{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO},  // identity rewritten
      '{Q_R2, Q_ZERO, Q_ZERO, Q_R2},     // quarter turn about z
      '{Q_MIN, Q_MIN, Q_MIN, Q_MIN},     // most negative, far from unit
      '{Q_MAX, Q_MAX, Q_MAX, Q_MAX},     // most positive, far from unit
      '{Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO},  // half turn about x
      '{Q_HALF, Q_HALF, Q_HALF, Q_HALF}, // third of a turn about the diagonal
      '{Q_MAX, Q_MIN, Q_MAX, Q_MIN},
      '{Q_R2, Q_ZERO, Q_R2, Q_ZERO}      // quarter turn about y
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [QUAT_WIDTH-1:0] csr_wdata;

   qrvs_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_if ();
   qrvs_rsp_if #(.COORD_WIDTH(COORD_WIDTH)) rsp_if ();

   quaternion_rotate_vertex_stream #(.COORD_WIDTH(COORD_WIDTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state: rotation and bounding box
   quat_type rot_model;
   longint   box_lo [3];
   longint   box_hi [3];
   logic     box_full;

   rsp_type awaited_results [$];
   int      fail_count;
   logic    calm;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // quaternion component times a value, rounded half away from zero
   // back to the value's format, saturated to the inner range
   function automatic longint quat_mul(input longint q, input longint v);
      logic [63:0]  aq;
      logic [63:0]  av;
      logic [127:0] mag;
      aq = (q < 0) ? 64'(-q) : 64'(q);
      av = (v < 0) ? 64'(-v) : 64'(v);
      mag = ({64'd0, aq} * {64'd0, av} + (128'd1 << (QUAT_FRAC - 1))) >> QUAT_FRAC;
      if (mag > 128'(SUM_LIM))
         mag = 128'(SUM_LIM);
      return ((q < 0) != (v < 0)) ? -$signed(mag[63:0]) : $signed(mag[63:0]);
   endfunction

   function automatic longint sat_add(input longint a, input longint b);
      longint s;
      s = a + b;
      return (s > SUM_LIM) ? SUM_LIM : ((s < -SUM_LIM) ? -SUM_LIM : s);
   endfunction

   function automatic longint coord_sat(input longint a);
      return (a > COORD_HI) ? COORD_HI : ((a < COORD_LO) ? COORD_LO : a);
   endfunction

   function automatic vec3_type cross3(input vec3_type a, input vec3_type b);
      vec3_type r;
      r[0] = sat_add(quat_mul(a[1], b[2]), -quat_mul(a[2], b[1]));
      r[1] = sat_add(quat_mul(a[2], b[0]), -quat_mul(a[0], b[2]));
      r[2] = sat_add(quat_mul(a[0], b[1]), -quat_mul(a[1], b[0]));
      return r;
   endfunction

   // v + 2*(w*(q x v) + q x (q x v))
   function automatic vec3_type turn_vector(input vec3_type v);
      vec3_type q;
      vec3_type t1;
      vec3_type t2;
      vec3_type r;
      longint   w;
      longint   s;
      w = longint'(rot_model.w);
      q = '{longint'(rot_model.x), longint'(rot_model.y), longint'(rot_model.z)};
      t1 = cross3(q, v);
      t2 = cross3(q, t1);
      for (int i = 0; i < 3; i++) begin
         s = sat_add(quat_mul(w, t1[i]), t2[i]);
         r[i] = coord_sat(sat_add(v[i], sat_add(s, s)));
      end
      return r;
   endfunction

   // expected result of one item; updates the box as the block does
   function automatic rsp_type item_result(input req_type item);
      rsp_type  res;
      vec3_type pos;
      vec3_type nrm;
      vec3_type rp;
      vec3_type rn;
      longint   kw;
      longint   rw;
      longint   rx;
      longint   ry;
      longint   rz;
      res = '0;
      pos = '{longint'(item.in_x), longint'(item.in_y), longint'(item.in_z)};
      nrm = '{longint'(item.normal_x), longint'(item.normal_y), longint'(item.normal_z)};
      kw = longint'(item.in_w);
      rw = longint'(rot_model.w);
      rx = longint'(rot_model.x);
      ry = longint'(rot_model.y);
      rz = longint'(rot_model.z);
      case (item.func)
         FN_VERTEX, FN_POINT: begin
            rp = turn_vector(pos);
            res.out_x = 32'(rp[0]);
            res.out_y = 32'(rp[1]);
            res.out_z = 32'(rp[2]);
            if (item.func == FN_VERTEX) begin
               rn = turn_vector(nrm);
               res.aux_x = 32'(rn[0]);
               res.aux_y = 32'(rn[1]);
               res.aux_z = 32'(rn[2]);
               // the first vertex after reset or clear seeds the box
               for (int i = 0; i < 3; i++) begin
                  if (!box_full || rp[i] < box_lo[i])
                     box_lo[i] = rp[i];
                  if (!box_full || rp[i] > box_hi[i])
                     box_hi[i] = rp[i];
               end
               box_full = 1'b1;
            end
         end
         FN_KEY: begin
            // hamilton product key * rot
            res.out_x = 32'(coord_sat(sat_add(sat_add(quat_mul(rx, kw), quat_mul(rw, pos[0])),
                        sat_add(quat_mul(rz, pos[1]), -quat_mul(ry, pos[2])))));
            res.out_y = 32'(coord_sat(sat_add(sat_add(quat_mul(ry, kw), quat_mul(rw, pos[1])),
                        sat_add(quat_mul(rx, pos[2]), -quat_mul(rz, pos[0])))));
            res.out_z = 32'(coord_sat(sat_add(sat_add(quat_mul(rz, kw), quat_mul(rw, pos[2])),
                        sat_add(quat_mul(ry, pos[0]), -quat_mul(rx, pos[1])))));
            res.out_w = 32'(coord_sat(sat_add(sat_add(quat_mul(rw, kw), -quat_mul(rx, pos[0])),
                        sat_add(-quat_mul(ry, pos[1]), -quat_mul(rz, pos[2])))));
         end
         FN_REPORT: begin
            // an empty box reports its registers as they stand
            res.out_x = 32'(box_lo[0]);
            res.out_y = 32'(box_lo[1]);
            res.out_z = 32'(box_lo[2]);
            res.aux_x = 32'(box_hi[0]);
            res.aux_y = 32'(box_hi[1]);
            res.aux_z = 32'(box_hi[2]);
         end
         FN_CLEAR: begin
            for (int i = 0; i < 3; i++) begin
               box_lo[i] = 0;
               box_hi[i] = 0;
            end
            box_full = 1'b0;
         end
         default: ;
      endcase
      res.box_valid = box_full;
      return res;
   endfunction

   // raw random words half the time, else the extremes and small values
   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return C_MAX;
         1:       return C_MIN;
         2:       return 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
         3:       return 32'($urandom_range(0, 2)) - 32'd1;
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)
         item.func = FN_VERTEX;
      else if (roll < 55)
         item.func = FN_POINT;
      else if (roll < 75)
         item.func = FN_KEY;
      else if (roll < 87)
         item.func = FN_REPORT;
      else if (roll < 94)
         item.func = FN_CLEAR;
      else
         item.func = FUNC_WIDTH'($urandom_range(FN_UNUSED_5, FN_UNUSED_7));
      item.in_x     = pick_coord();
      item.in_y     = pick_coord();
      item.in_z     = pick_coord();
      item.in_w     = pick_coord();
      item.normal_x = pick_coord();
      item.normal_y = pick_coord();
      item.normal_z = pick_coord();
      return item;
   endfunction

   function automatic quat_type random_quat();
      quat_type q;
      q.w = QUAT_WIDTH'($urandom);
      q.x = QUAT_WIDTH'($urandom);
      q.y = QUAT_WIDTH'($urandom);
      q.z = QUAT_WIDTH'($urandom);
      return q;
   endfunction

   // offer one item and hold it until taken; valid stays high afterward
   task automatic send_item(input req_type item, input logic typed, input rsp_type want);
      rsp_type predicted;
      req_if.valid    <= 1'b1;
      req_if.func     <= item.func;
      req_if.in_x     <= item.in_x;
      req_if.in_y     <= item.in_y;
      req_if.in_z     <= item.in_z;
      req_if.in_w     <= item.in_w;
      req_if.normal_x <= item.normal_x;
      req_if.normal_y <= item.normal_y;
      req_if.normal_z <= item.normal_z;
      do
         @(posedge clock);
      while (!req_if.ready);
      // the predictor runs for typed rows too, to keep the box in step
      predicted = item_result(item);
      awaited_results.push_back(typed ? want : predicted);
   endtask

   // random gap in front of an item, none in the calm stretch
   task automatic sender_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      req_if.valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
   endtask

   // only called with the block idle
   task automatic set_rotation(input quat_type q);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROT_W;
      csr_wdata <= q.w;
      @(posedge clock);
      csr_index <= CSR_ROT_X;
      csr_wdata <= q.x;
      @(posedge clock);
      csr_index <= CSR_ROT_Y;
      csr_wdata <= q.y;
      @(posedge clock);
      csr_index <= CSR_ROT_Z;
      csr_wdata <= q.z;
      @(posedge clock);
      csr_we    <= 1'b0;
      rot_model = q;
   endtask

   task automatic check_result();
      rsp_type     got;
      rsp_type     want;
      logic [31:0] want_f;
      logic [31:0] got_f;
      got = '{rsp_if.out_x, rsp_if.out_y, rsp_if.out_z, rsp_if.out_w,
              rsp_if.aux_x, rsp_if.aux_y, rsp_if.aux_z, rsp_if.box_valid};
      if (awaited_results.size() == 0) begin
         $display("%0t: unexpected item out_x %0d out_y %0d out_z %0d",
                  $time, got.out_x, got.out_y, got.out_z);
         fail_count++;
         return;
      end
      want = awaited_results.pop_front();
      for (int k = 0; k < 8; k++) begin
         want_f = (k < 7) ? want[224 - 32 * k -: 32] : 32'(want.box_valid);
         got_f  = (k < 7) ? got[224 - 32 * k -: 32] : 32'(got.box_valid);
         if (want_f !== got_f) begin
            $display("%0t: %s expected %0d got %0d", $time, FIELD_NAMES[k],
                     $signed(want_f), $signed(got_f));
            fail_count++;
         end
      end
   endtask

   // result side: every handshake is compared with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         check_result();
   end

   // result side stalls in random bursts
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   initial begin : stimulus
      quat_type next_rot;
      // every input known from time zero
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_ROT_W;
      csr_wdata       <= '0;
      req_if.valid    <= 1'b0;
      req_if.func     <= FN_VERTEX;
      req_if.in_x     <= '0;
      req_if.in_y     <= '0;
      req_if.in_z     <= '0;
      req_if.in_w     <= '0;
      req_if.normal_x <= '0;
      req_if.normal_y <= '0;
      req_if.normal_z <= '0;
      calm       = 1'b0;
      fail_count = 0;
      // predictor after reset: identity rotation, empty zero box
      rot_model = '{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO};
      for (int i = 0; i < 3; i++) begin
         box_lo[i] = 0;
         box_hi[i] = 0;
      end
      box_full = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[k]) begin
         sender_gap();
         send_item(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].want);
      end
      drain();

      // random phases, each under its own rotation; the block is idle
      // at every rotation change since drain waits out every result
      for (int p = 0; p < NUM_PHASES; p++) begin
         next_rot = (p < $size(ROT_PLAN)) ? ROT_PLAN[p] : random_quat();
         set_rotation(next_rot);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // last stretch of the run goes without gaps or stalls
            if (p == NUM_PHASES - 1 && n >= ITEMS_PER_PHASE - CALM_ITEMS)
               calm = 1'b1;
            sender_gap();
            send_item(random_item(), 1'b0, '0);
         end
         drain();
      end

      // catch anything extra the block may still put out
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule
